// File: sv/csvqp_pkg.sv
// csvqp_pkg: shared types and character codes for the CSV quoted field parser.
// No dependencies; imported by csvqp_core and csv_quoted_field_parser_unit.

package csvqp_pkg;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // Special characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One result item as produced by the parser step
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       byte_valid;
    logic       field_end;
    logic       line_end;
  } csvqp_res_t;

endpackage

// File: sv/csvqp_core.sv
// csvqp_core: parser state registers and the per-character step logic.
// Depends on csvqp_pkg. Produces at most one result per accepted item.

module csvqp_core import csvqp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       op,
  input  logic [7:0] ch,
  output csvqp_res_t res
);

  logic       inside_quotes_r, inside_quotes_nxt;
  logic       quote_pending_r, quote_pending_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       has_content_r, has_content_nxt;

  logic       do_content;
  logic [7:0] content_ch;
  logic       do_close;
  logic       close_eol;
  logic       outside;
  logic       close_emit;

  // Classify the item: content byte, field close, or no-result control
  always_comb begin
    do_content        = 1'b0;
    content_ch        = ch;
    do_close          = 1'b0;
    close_eol         = 1'b0;
    outside           = 1'b0;
    inside_quotes_nxt = inside_quotes_r;
    quote_pending_nxt = quote_pending_r;

    if (op == OP_EOL) begin
      do_close          = 1'b1;
      close_eol         = 1'b1;
      inside_quotes_nxt = 1'b0;
      quote_pending_nxt = 1'b0;
    end else if (quote_pending_r) begin
      quote_pending_nxt = 1'b0;
      if (ch == CH_QUOTE) begin
        // doubled quote: literal quote
        do_content = 1'b1;
        content_ch = CH_QUOTE;
      end else begin
        // lone quote closed the section; byte handled as outside
        inside_quotes_nxt = 1'b0;
        outside           = 1'b1;
      end
    end else if (inside_quotes_r) begin
      if (ch == CH_QUOTE) begin
        quote_pending_nxt = 1'b1;
      end else begin
        do_content = 1'b1;
      end
    end else begin
      outside = 1'b1;
    end

    if (outside) begin
      if (ch == CH_QUOTE) begin
        inside_quotes_nxt = 1'b1;
      end else if (ch == CH_COMMA) begin
        do_close = 1'b1;
      end else if (ch != CH_CR) begin
        do_content = 1'b1;
      end
    end
  end

  // Hold-back register and result formation
  assign close_emit = held_valid_r && (held_byte_r != CH_QUOTE);

  always_comb begin
    held_byte_nxt   = held_byte_r;
    held_valid_nxt  = held_valid_r;
    has_content_nxt = has_content_r;
    res             = '0;

    if (do_close) begin
      res.valid       = 1'b1;
      res.byte_valid  = close_emit;
      res.data        = close_emit ? held_byte_r : 8'h00;
      res.field_end   = 1'b1;
      res.line_end    = close_eol;
      held_byte_nxt   = 8'h00;
      held_valid_nxt  = 1'b0;
      has_content_nxt = 1'b0;
    end else if (do_content) begin
      if (!has_content_r) begin
        // first content byte: a leading quote is stripped
        has_content_nxt = 1'b1;
        if (content_ch != CH_QUOTE) begin
          held_byte_nxt  = content_ch;
          held_valid_nxt = 1'b1;
        end
      end else begin
        if (held_valid_r) begin
          res.valid      = 1'b1;
          res.byte_valid = 1'b1;
          res.data       = held_byte_r;
        end
        held_byte_nxt  = content_ch;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // State registers, updated only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_quotes_r <= 1'b0;
      quote_pending_r <= 1'b0;
      held_byte_r     <= 8'h00;
      held_valid_r    <= 1'b0;
      has_content_r   <= 1'b0;
    end else if (step_en) begin
      inside_quotes_r <= inside_quotes_nxt;
      quote_pending_r <= quote_pending_nxt;
      held_byte_r     <= held_byte_nxt;
      held_valid_r    <= held_valid_nxt;
      has_content_r   <= has_content_nxt;
    end
  end

endmodule

// File: sv/csv_quoted_field_parser_unit.sv
// csv_quoted_field_parser_unit: top level of the CSV quoted field parser.
// Depends on csvqp_pkg and csvqp_core; holds the result output register.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   in_op, in_char_in
//   out      output     out_valid/out_stall out_byte, out_byte_valid,
//                                           out_field_end, out_line_end
//
// One item per cycle while in_stall is low: the step logic sits between the
// parser state and a single output register, so a result appears the cycle after its item.
// Reset (rst_n low, synchronous) clears parser state and the output valid.
// in_stall is high only while the output register is full and stalled; an
// item is still taken while the held result drains in the same cycle.

module csv_quoted_field_parser_unit import csvqp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_field_end,
  output logic       out_line_end
);

  logic       in_acc;
  csvqp_res_t step_res;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bvalid_r;
  logic       out_fend_r;
  logic       out_lend_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  csvqp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .op      (in_op),
    .ch      (in_char_in),
    .res     (step_res)
  );

  // Output register: load on a new result, clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= step_res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && step_res.valid) begin
      out_byte_r   <= step_res.data;
      out_bvalid_r <= step_res.byte_valid;
      out_fend_r   <= step_res.field_end;
      out_lend_r   <= step_res.line_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bvalid_r;
  assign out_field_end  = out_fend_r;
  assign out_line_end   = out_lend_r;

  // Checks
  a_line_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_field_end)
    else $error("line end without field end");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'h00)
    else $error("out_byte nonzero without byte_valid");

  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_op == OP_EOL |=> out_valid && out_line_end && out_field_end)
    else $error("end of line item gave no line end result");

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for csv_quoted_field_parser_unit.
// Depends on csvqp_pkg and the parser RTL; a scoreboard class predicts each
// result from the accepted items, and plain tasks drive CSV lines with stalls.

module testbench;
  import csvqp_pkg::*;

  localparam int TARGET_ITEMS    = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int MAX_REPORTS     = 10;

  typedef enum int {FLD_PLAIN, FLD_QUOTED, FLD_NOISE} field_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       fend;
    logic       lend;
  } field_out_t;

  // Field parser prediction and result checking
  class csv_field_scoreboard_t;
    bit         in_quote;
    bit         quote_seen;
    bit         field_started;
    bit         held_ok;
    bit [7:0]   held_char;
    field_out_t expected_q[$];
    int         mismatches;
    int         results_checked;
    int         lines_seen;
    int         fields_seen;
    int         bytes_seen;

    function void push_out(bit ok, bit [7:0] b, bit fe, bit le);
      field_out_t r;
      r.data    = ok ? b : 8'h00;
      r.byte_ok = ok;
      r.fend    = fe;
      r.lend    = le;
      if (ok) bytes_seen++;
      expected_q = {expected_q, r};
    endfunction

    // content byte: a leading quote is dropped, otherwise one byte is held back
    function void take_char(bit [7:0] c);
      if (!field_started) begin
        field_started = 1'b1;
        if (c != CH_QUOTE) begin
          held_char = c;
          held_ok   = 1'b1;
        end
      end else begin
        if (held_ok) push_out(1'b1, held_char, 1'b0, 1'b0);
        held_char = c;
        held_ok   = 1'b1;
      end
    endfunction

    // field close: a trailing quote in the held byte is stripped
    function void close_field(bit at_eol);
      push_out(held_ok && held_char != CH_QUOTE, held_char, 1'b1, at_eol);
      held_char     = 8'h00;
      held_ok       = 1'b0;
      field_started = 1'b0;
      fields_seen++;
    endfunction

    function void note_item(logic op, logic [7:0] c);
      if (op == OP_EOL) begin
        close_field(1'b1);
        in_quote   = 1'b0;
        quote_seen = 1'b0;
        lines_seen++;
        return;
      end
      if (quote_seen) begin
        quote_seen = 1'b0;
        if (c == CH_QUOTE) begin
          take_char(CH_QUOTE);
          return;
        end
        in_quote = 1'b0;
      end else if (in_quote) begin
        if (c == CH_QUOTE) quote_seen = 1'b1;
        else take_char(c);
        return;
      end
      // outside quotes
      if (c == CH_QUOTE) in_quote = 1'b1;
      else if (c == CH_COMMA) close_field(1'b0);
      else if (c != CH_CR) take_char(c);
    endfunction

    function void report(string what, field_out_t want, field_out_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s at %0t: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                 what, $time, want.data, want.byte_ok, want.fend, want.lend,
                 got.data, got.byte_ok, got.fend, got.lend);
    endfunction

    function void check_result(field_out_t got);
      field_out_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (want.data !== got.data || want.byte_ok !== got.byte_ok ||
          want.fend !== got.fend || want.lend !== got.lend)
        report("result mismatch", want, got);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic       in_op          = OP_CHAR;
  logic [7:0] in_char_in     = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_field_end;
  logic       out_line_end;

  csv_field_scoreboard_t sb = new;

  int items_sent;
  int held_cycles;
  int stalled_cycles;
  int idle_run;
  bit quiet_line;
  bit hold_req;
  bit hold_done;

  csv_quoted_field_parser_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_field_end  (out_field_end),
    .out_line_end   (out_line_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one item after a random gap and wait until it is taken
  task automatic send_item(logic op, logic [7:0] c);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (quiet_line || (hold_req && !hold_done) || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
  endtask

  // One field of a random line; quoted fields mostly well formed
  task automatic send_field(field_kind_t kind);
    int         n;
    int         r;
    logic [7:0] c;
    n = $urandom_range(0, 5);
    if (kind == FLD_QUOTED) send_item(OP_CHAR, CH_QUOTE);
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      case (kind)
        FLD_PLAIN: begin
          if (c == CH_QUOTE || c == CH_COMMA) c ^= 8'h40;
        end
        FLD_QUOTED: begin
          if (r < 30) begin
            send_item(OP_CHAR, CH_QUOTE);
            c = CH_QUOTE;
          end else if (r < 40) c = CH_COMMA;
          else if (r < 45) c = CH_CR;
          else if (c == CH_QUOTE) c ^= 8'h40;
        end
        default: begin
          if (r < 35) c = CH_QUOTE;
          else if (r < 50) c = CH_COMMA;
          else if (r < 60) c = CH_CR;
        end
      endcase
      send_item(OP_CHAR, c);
    end
    // sometimes leave the quoted section open
    if (kind == FLD_QUOTED && $urandom_range(0, 4) != 0) send_item(OP_CHAR, CH_QUOTE);
  endtask

  task automatic send_line();
    int nf;
    int r;
    nf         = $urandom_range(1, 4);
    quiet_line = ($urandom_range(0, 4) == 0);
    for (int f = 0; f < nf; f++) begin
      r = $urandom_range(0, 99);
      if (f > 0) send_item(OP_CHAR, CH_COMMA);
      if (r < 45) send_field(FLD_PLAIN);
      else if (r < 85) send_field(FLD_QUOTED);
      else send_field(FLD_NOISE);
    end
    send_item(OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: short and long stalls, quiet stretches, one long hold-off
  initial begin
    int burst;
    int quiet_left;
    int r;
    burst      = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          quiet_left = $urandom_range(20, 60);
          out_stall <= 1'b0;
        end else if (r < 75) out_stall <= 1'b0;
        else if (r < 95) begin
          burst = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          burst = $urandom_range(8, 30);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({out_byte, out_byte_valid, out_field_end, out_line_end});
      if (in_valid && !in_stall) sb.note_item(in_op, in_char_in);
      if (in_valid && in_stall) held_cycles++;
      if (out_valid && out_stall) stalled_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_run, sb.pending());
        $display("FAIL csv_quoted_field_parser_unit");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty line, byte extremes with a dropped CR
    send_item(OP_EOL, 8'hFF);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, CH_CR);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_EOL, 8'h00);
    // doubled quote, lone closing quote then comma, lone-quote field, pending quote at EOL
    send_text("\"a\"\"b\",\"\"\"\"");
    send_item(OP_EOL, 8'hA5);
    // CR kept inside quotes, unterminated quotes at EOL
    send_item(OP_CHAR, CH_QUOTE);
    send_item(OP_CHAR, CH_CR);
    send_item(OP_EOL, 8'h5A);
    // trailing quote stripped
    send_text("\"a\"\"\"");
    send_item(OP_EOL, 8'h01);

    // random lines; the first ones run into the long receiver hold-off
    hold_req = 1'b1;
    while (items_sent < TARGET_ITEMS + 26) send_line();
    in_valid <= 1'b0;

    // let the monitor note the last accepted item before draining
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d lines, %0d fields, %0d content bytes; %0d results checked.",
             sb.lines_seen, sb.fields_seen, sb.bytes_seen, sb.results_checked);
    $display("Input held back %0d cycles, output stalled %0d cycles, %0d mismatches.",
             held_cycles, stalled_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS csv_quoted_field_parser_unit");
    end else begin
      $display("FAIL csv_quoted_field_parser_unit");
    end
    $finish;
  end

endmodule
